// ===== hw/rtl/sync_length_frame_deframer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slfd_pkg.sv =====
`default_nettype none

package slfd_pkg;

  localparam int MAX_LEN = 30;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] MAX_LEN_B  = 8'(MAX_LEN);
  localparam logic [7:0] SYNC_RESET = 8'hED;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_BADLEN = 2'd3;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] index;
    logic       last;
  } slfd_rec_t;

  typedef struct packed {
    logic      valid;
    slfd_rec_t rec;
  } slfd_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_length_frame_deframer.sv =====
// Sync/length frame deframer. Feed received serial bytes on in_byte; frames
// look like <sync> <len> <body...>. While hunting, every byte other than the
// sync byte (cfg register, 0xED after reset) is dropped without a result. The
// byte after sync is the body length: above MAX_LEN (30) it gives one request
// of kind bad-length, zero gives one empty-frame request, and both return to
// hunting. Otherwise each body byte gives one request: the first as the
// command (index 0), the rest as data with their index, the final one with
// out_last set. Sync bytes that open a frame, in-range nonzero lengths and
// other hunted bytes give no request. One byte is taken per clock while
// in_ready is high; the front classifies each accepted byte and pushes its
// request into a two-entry queue at the edge that accepts it, and the output
// register loads it when that register is empty or being drained. in_ready
// drops only when that queue is full, which happens only while the output
// side stalls. Write cfg only while idle.

`default_nettype none

module sync_length_frame_deframer
  import slfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [4:0]      out_index,
  output logic            out_last
);

  slfd_push_t push;
  logic       push_ready;
  logic       q_valid;
  logic       q_ready;
  slfd_rec_t  q_rec;

  // Front: hold the frame phase and counters, classify each byte, and
  // push a request record when the byte yields one.
  slfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .q_ready   (push_ready),
    .push      (push)
  );

  // Queue: decouple the classifier from the output stall.
  slfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_rec    (q_rec)
  );

  // Back: drive the registered result channel.
  slfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_rec     (q_rec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/slfd_front.sv =====
`default_nettype none

module slfd_front
  import slfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_ready,
  output slfd_push_t      push
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sync_r;
  logic             accept;
  logic             is_last;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign is_last  = (left_r <= CNT_W'(1));

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    push      = '0;
    if (accept) begin
      unique case (phase_r)
        PH_LEN: begin
          if (in_byte > MAX_LEN_B) begin
            phase_nxt     = PH_HUNT;
            left_nxt      = '0;
            pos_nxt       = '0;
            push.valid    = 1'b1;
            push.rec.kind = KIND_BADLEN;
            push.rec.last = 1'b1;
          end else if (in_byte == 8'd0) begin
            phase_nxt     = PH_HUNT;
            left_nxt      = '0;
            pos_nxt       = '0;
            push.valid    = 1'b1;
            push.rec.kind = KIND_EMPTY;
            push.rec.last = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
            left_nxt  = CNT_W'(in_byte);
            pos_nxt   = '0;
          end
        end
        PH_BODY: begin
          push.valid     = 1'b1;
          push.rec.kind  = (pos_r == '0) ? KIND_CMD : KIND_DATA;
          push.rec.data  = in_byte;
          push.rec.index = 5'(pos_r);
          push.rec.last  = is_last;
          if (is_last) begin
            phase_nxt = PH_HUNT;
            left_nxt  = '0;
            pos_nxt   = '0;
          end else begin
            left_nxt = CNT_W'(left_r - 1'b1);
            pos_nxt  = CNT_W'(pos_r + 1'b1);
          end
        end
        default: begin
          // hunting, and the spare code behaves the same
          phase_nxt = PH_HUNT;
          if (in_byte == sync_r) begin
            phase_nxt = PH_LEN;
            left_nxt  = '0;
            pos_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      pos_r   <= '0;
      sync_r  <= SYNC_RESET;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slfd_queue.sv =====
`default_nettype none

module slfd_queue
  import slfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire slfd_push_t push,
  output logic            push_ready,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output slfd_rec_t       pop_rec
);

  slfd_rec_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= QCNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= QCNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slfd_back.sv =====
`default_nettype none

module slfd_back
  import slfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  wire slfd_rec_t q_rec,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [4:0]     out_index,
  output logic           out_last
);

  logic      valid_r;
  slfd_rec_t rec_r;

  // refill the output register when it is empty or being drained
  assign q_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      rec_r <= q_rec;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = rec_r.kind;
  assign out_byte  = rec_r.data;
  assign out_index = rec_r.index;
  assign out_last  = rec_r.last;

endmodule

`default_nettype wire

// ===== hw/rtl/slfd_checker.sv =====
`default_nettype none

`include "sync_length_frame_deframer_defines.svh"

module slfd_checker
  import slfd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic [4:0] out_index,
  input wire logic       out_last
);

  `SLFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_index)
    && $stable(out_last), "stalled request changed")

  `SLFD_ASSERT_NOW(a_flush_shape,
    out_valid && (out_kind == KIND_EMPTY || out_kind == KIND_BADLEN),
    out_last && out_byte == 8'd0 && out_index == 5'd0,
    "empty or bad-length request not zero and last")

  `SLFD_ASSERT_NOW(a_cmd_index, out_valid && out_kind == KIND_CMD,
    out_index == 5'd0, "command not at index zero")

  `SLFD_ASSERT_NOW(a_data_index, out_valid && out_kind == KIND_DATA,
    out_index != 5'd0, "data byte at index zero")

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slfd_pkg::*;

  // Phases of the frame parser as the predictor tracks them.
  typedef enum logic [1:0] {
    HUNTING,
    AWAIT_LEN,
    IN_BODY
  } frame_phase_t;

  // How a directed row is checked: from the predictor, as a byte that gives
  // no request, or against the request typed into the row.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_TYPED
  } row_check_t;

  typedef struct {
    logic [7:0] b;
    row_check_t how;
    slfd_rec_t  want;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [1:0] out_kind;
  wire  [7:0] out_byte;
  wire  [4:0] out_index;
  wire        out_last;

  sync_length_frame_deframer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .out_index(out_index),
    .out_last (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (about 1100 bytes, each
  // waiting out a long send gap plus a long receive stall).
  initial begin
    #5ms;
    $display("sync_length_frame_deframer regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Frame predictor: its own copy of the sync register and parser state.
  // ---------------------------------------------------------------------
  logic [7:0]   fr_sync  = SYNC_RESET;
  frame_phase_t fr_phase = HUNTING;
  logic [7:0]   fr_left  = 8'd0;
  logic [7:0]   fr_pos   = 8'd0;

  // Requests still owed by the block, oldest first.
  slfd_rec_t frames_due[$];
  int        mismatches = 0;

  // Set while a stretch runs with no gaps on either side.
  bit no_gaps = 1'b0;

  // Advance the predictor by one accepted byte; return 1 with the request it
  // yields, or 0 when the byte yields none.
  function automatic bit deframe_byte(input logic [7:0] b, output slfd_rec_t rec);
    rec = '0;
    case (fr_phase)
      AWAIT_LEN: begin
        if (b > MAX_LEN_B || b == 8'd0) begin
          // Overlong length flushes the frame; zero length is an empty frame.
          rec.kind = (b == 8'd0) ? KIND_EMPTY : KIND_BADLEN;
          rec.last = 1'b1;
          fr_phase = HUNTING;
          fr_left  = 8'd0;
          fr_pos   = 8'd0;
          return 1'b1;
        end
        fr_phase = IN_BODY;
        fr_left  = b;
        fr_pos   = 8'd0;
        return 1'b0;
      end
      IN_BODY: begin
        // A sync value in the body is just another body byte.
        rec.kind  = (fr_pos == 8'd0) ? KIND_CMD : KIND_DATA;
        rec.data  = b;
        rec.index = fr_pos[4:0];
        rec.last  = (fr_left <= 8'd1);
        if (rec.last) begin
          fr_phase = HUNTING;
          fr_left  = 8'd0;
          fr_pos   = 8'd0;
        end else begin
          fr_left = fr_left - 8'd1;
          fr_pos  = fr_pos + 8'd1;
        end
        return 1'b1;
      end
      default: begin
        // Hunting: drop everything but the sync byte, which itself is silent.
        fr_phase = HUNTING;
        if (b == fr_sync) begin
          fr_phase = AWAIT_LEN;
          fr_left  = 8'd0;
          fr_pos   = 8'd0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and hold it until the block takes it. Returns at the
  // accepting edge with in_valid still high, so a back-to-back byte can
  // follow in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send a byte and book whatever request the predictor says it yields.
  task automatic feed(input logic [7:0] b);
    slfd_rec_t rec;
    send_byte(b);
    if (deframe_byte(b, rec)) frames_due.push_back(rec);
  endtask

  // Drop valid, wait for every owed request, then cover the queue and output
  // register in case the last bytes were silent ones still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One configuration phase: program the sync byte, then mostly well-formed
  // frames with random content, mixed with hunted noise and broken headers.
  // Only frame bytes count toward the quota; noise bytes do not.
  task automatic run_phase(input logic [7:0] sync_v, input int quota, input bit force_max);
    int counted;
    int len;
    int r;
    int k;
    counted = 0;
    cfg_we    <= 1'b1;
    cfg_wdata <= sync_v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    fr_sync = sync_v;
    while (counted < quota) begin
      // Run the opening stretch of every phase with both sides streaming.
      no_gaps = (counted < 40);
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 4);
        repeat (k) feed(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (force_max) begin
          len       = MAX_LEN;
          force_max = 1'b0;
        end else if (r < 6) begin
          len = 0;
        end else if (r < 13) begin
          len = $urandom_range(MAX_LEN + 1, 255);
        end else if (r < 16) begin
          len = sync_v;
        end else if (r < 22) begin
          len = MAX_LEN;
        end else if (r < 85) begin
          len = $urandom_range(1, 6);
        end else begin
          len = $urandom_range(7, MAX_LEN - 1);
        end
        feed(sync_v);
        feed(8'(len));
        counted += 2;
        // Follow the predictor: stream body bytes as long as a body is open,
        // which also covers headers that noise left misaligned.
        while (fr_phase == IN_BODY) begin
          feed(($urandom_range(0, 7) == 0) ? sync_v : 8'($urandom_range(0, 255)));
          counted++;
        end
      end
    end
    no_gaps = 1'b0;
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Directed table, run at the reset sync value 0xED.
  // ---------------------------------------------------------------------
  dir_row_t dir_rows [19] = '{
    '{8'h00, ROW_SILENT, '0},                                     // noise while hunting
    '{8'hFF, ROW_SILENT, '0},
    '{8'hED, ROW_SILENT, '0},                                     // sync itself is silent
    '{8'h00, ROW_TYPED,  '{KIND_EMPTY,  8'h00, 5'd0, 1'b1}},      // empty frame
    '{8'hED, ROW_SILENT, '0},
    '{8'h1F, ROW_TYPED,  '{KIND_BADLEN, 8'h00, 5'd0, 1'b1}},      // one over the limit
    '{8'hED, ROW_SILENT, '0},
    '{8'hFF, ROW_TYPED,  '{KIND_BADLEN, 8'h00, 5'd0, 1'b1}},      // largest length
    '{8'hED, ROW_SILENT, '0},
    '{8'hED, ROW_TYPED,  '{KIND_BADLEN, 8'h00, 5'd0, 1'b1}},      // sync as the length
    '{8'hED, ROW_SILENT, '0},
    '{8'h01, ROW_SILENT, '0},
    '{8'hA5, ROW_TYPED,  '{KIND_CMD,    8'hA5, 5'd0, 1'b1}},      // command-only frame
    '{8'hED, ROW_SILENT, '0},
    '{8'h03, ROW_SILENT, '0},
    '{8'hED, ROW_PREDICT, '0},                                    // sync inside a body
    '{8'h00, ROW_PREDICT, '0},
    '{8'hFF, ROW_PREDICT, '0},
    '{8'h5A, ROW_SILENT, '0}                                      // back to hunting
  };

  // ---------------------------------------------------------------------
  // Receive side: random stalls on out_ready.
  // ---------------------------------------------------------------------
  initial begin : ready_gen
    int stall;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Check each accepted request against the oldest one owed. Values read
  // here are the ones present just before the edge.
  always @(posedge clk) begin : result_check
    slfd_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected request: kind %0d byte 0x%02h index %0d last %0d",
               out_kind, out_byte, out_index, out_last);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte);
          mismatches++;
        end
        if (out_index !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_index);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    slfd_rec_t rec;
    bit        got;
    // Hold reset, then release it once, for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b);
      got = deframe_byte(dir_rows[i].b, rec);
      case (dir_rows[i].how)
        ROW_TYPED:   frames_due.push_back(dir_rows[i].want);
        ROW_PREDICT: if (got) frames_due.push_back(rec);
        default:     ;
      endcase
    end
    settle();

    // Sweep the sync register: both extremes, two random values, and back
    // to the reset value. The first and last phases open with a full-length frame.
    run_phase(8'h00, 155, 1'b1);
    run_phase(8'hFF, 155, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 155, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 155, 1'b0);
    run_phase(SYNC_RESET, 155, 1'b1);

    if (mismatches == 0) begin
      $display("sync_length_frame_deframer regression: pass");
    end else begin
      $display("sync_length_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
